// File: rtl/core/lpr_pkg.sv
package lpr_pkg;

  localparam int LPR_ROUTES  = 16;
  localparam int LPR_PORTS   = 4;

  localparam int ACTION_W    = 2;
  localparam int SLOT_W      = 4;
  localparam int ADDR_W      = 32;
  localparam int PORT_W      = 2;

  // command queue between front and back
  localparam int LPR_QDEPTH  = 2;
  localparam int LPR_QPTR_W  = $clog2(LPR_QDEPTH);

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP     = 2'd0,
    ACT_WRITE      = 2'd1,
    ACT_INVALIDATE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_LOOKUP,
    CMD_WRITE,
    CMD_INVAL
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_LAST,
    BK_EMIT
  } back_state_t;

  // key carries the prefix on a write and the address on a lookup
  typedef struct packed {
    cmd_kind_t          kind;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  key;
    logic [ADDR_W-1:0]  mask;
    logic [ADDR_W-1:0]  gateway;
    logic [PORT_W-1:0]  port;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  prefix;
    logic [ADDR_W-1:0]  mask;
    logic [ADDR_W-1:0]  gateway;
    logic [PORT_W-1:0]  port;
  } route_entry_t;

endpackage

// File: rtl/core/lpr_ifs.sv
interface lpr_in_if;
  import lpr_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACTION_W-1:0] action;
  logic [SLOT_W-1:0] entry_slot;
  logic [ADDR_W-1:0] prefix_value;
  logic [ADDR_W-1:0] prefix_mask;
  logic [ADDR_W-1:0] gateway_value;
  logic [PORT_W-1:0] port_value;
  logic [ADDR_W-1:0] lookup_address;

  modport source (
    output valid, action, entry_slot, prefix_value, prefix_mask,
           gateway_value, port_value, lookup_address,
    input  ready
  );

  modport sink (
    input  valid, action, entry_slot, prefix_value, prefix_mask,
           gateway_value, port_value, lookup_address,
    output ready
  );

endinterface

interface lpr_out_if;
  import lpr_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [ADDR_W-1:0] next_hop;
  logic [PORT_W-1:0] out_port;

  modport source (
    output valid, found, next_hop, out_port,
    input  ready
  );

  modport sink (
    input  valid, found, next_hop, out_port,
    output ready
  );

endinterface

// File: rtl/core/lpr_front.sv
module lpr_front #(
  parameter int ROUTES = lpr_pkg::LPR_ROUTES,
  parameter int PORTS  = lpr_pkg::LPR_PORTS
) (
  lpr_in_if.sink         in_ch,
  output logic           push_valid,
  input  logic           push_ready,
  output lpr_pkg::cmd_t  push_cmd
);
  import lpr_pkg::*;

  logic              slot_ok;
  logic [PORT_W-1:0] port_sat;

  assign slot_ok  = ({{(32-SLOT_W){1'b0}}, in_ch.entry_slot} < 32'(ROUTES));
  assign port_sat = ({{(32-PORT_W){1'b0}}, in_ch.port_value} >= 32'(PORTS)) ?
                    PORT_W'(PORTS - 1) : in_ch.port_value;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_cmd.slot    = in_ch.entry_slot;
    push_cmd.mask    = in_ch.prefix_mask;
    push_cmd.gateway = in_ch.gateway_value;
    push_cmd.port    = port_sat;
    push_cmd.key     = in_ch.prefix_value;
    case (in_ch.action)
      ACT_LOOKUP: begin
        push_cmd.kind = CMD_LOOKUP;
        push_cmd.key  = in_ch.lookup_address;
      end
      ACT_WRITE: begin
        push_cmd.kind = slot_ok ? CMD_WRITE : CMD_NOP;
      end
      ACT_INVALIDATE: begin
        push_cmd.kind = slot_ok ? CMD_INVAL : CMD_NOP;
      end
      default: begin
        push_cmd.kind = CMD_NOP;
      end
    endcase
  end

endmodule

// File: rtl/core/lpr_cmd_fifo.sv
module lpr_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  lpr_pkg::cmd_t  push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output lpr_pkg::cmd_t  pop_cmd
);
  import lpr_pkg::*;

  cmd_t                  slots_r [LPR_QDEPTH];
  logic [LPR_QPTR_W-1:0] wr_ptr_r;
  logic [LPR_QPTR_W-1:0] rd_ptr_r;
  logic [LPR_QPTR_W:0]   count_r;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count_r != (LPR_QPTR_W+1)'(LPR_QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= LPR_QPTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= LPR_QPTR_W'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_r <= (LPR_QPTR_W+1)'(count_r + 1'b1);
      end else if (do_pop && !do_push) begin
        count_r <= (LPR_QPTR_W+1)'(count_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/core/lpr_back.sv
module lpr_back #(
  parameter int ROUTES = lpr_pkg::LPR_ROUTES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  lpr_pkg::cmd_t  cmd,
  lpr_out_if.source      out_ch
);
  import lpr_pkg::*;

  localparam int IDX_W = $clog2(ROUTES);

  back_state_t       state_r, state_nxt;
  route_entry_t      table_mem [ROUTES];
  logic [ROUTES-1:0] valid_r;
  route_entry_t      rd_entry_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  scan_idx_r;
  logic              cmp_en_r;
  logic [ADDR_W-1:0] addr_r;

  logic              best_hit_r, best_hit_nxt;
  logic [ADDR_W-1:0] best_mask_r, best_mask_nxt;
  logic [ADDR_W-1:0] best_gw_r, best_gw_nxt;
  logic [PORT_W-1:0] best_port_r, best_port_nxt;

  logic              out_valid_r;
  logic              out_found_r;
  logic [ADDR_W-1:0] out_hop_r;
  logic [PORT_W-1:0] out_port_r;

  logic              out_free;
  logic              pop;
  logic              start_scan;
  logic              tbl_we;
  logic              vld_clr;
  logic              load_zero;
  logic              load_best;
  logic              take;
  logic [IDX_W-1:0]  wr_idx;
  route_entry_t      wr_entry;

  assign out_free = !out_valid_r || out_ch.ready;
  assign wr_idx   = IDX_W'(cmd.slot);

  always_comb begin
    wr_entry.prefix  = cmd.key;
    wr_entry.mask    = cmd.mask;
    wr_entry.gateway = cmd.gateway;
    wr_entry.port    = cmd.port;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && out_free && cmd.kind == CMD_LOOKUP) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_idx_r == IDX_W'(ROUTES - 1)) begin
          state_nxt = BK_LAST;
        end
      end
      BK_LAST: begin
        state_nxt = out_free ? BK_IDLE : BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    pop        = 1'b0;
    start_scan = 1'b0;
    tbl_we     = 1'b0;
    vld_clr    = 1'b0;
    load_zero  = 1'b0;
    load_best  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        pop = cmd_valid && out_free;
        if (pop) begin
          case (cmd.kind)
            CMD_LOOKUP: start_scan = 1'b1;
            CMD_WRITE: begin
              tbl_we    = 1'b1;
              load_zero = 1'b1;
            end
            CMD_INVAL: begin
              vld_clr   = 1'b1;
              load_zero = 1'b1;
            end
            default: load_zero = 1'b1;
          endcase
        end
      end
      BK_LAST: load_best = out_free;
      BK_EMIT: load_best = out_free;
      default: begin
      end
    endcase
  end

  assign cmd_ready = pop;

  // compare the entry read in the previous cycle against the running best
  always_comb begin
    take = cmp_en_r && rd_vld_r && ((addr_r & rd_entry_r.mask) == rd_entry_r.prefix) &&
           (!best_hit_r || (rd_entry_r.mask > best_mask_r));
    best_hit_nxt  = best_hit_r;
    best_mask_nxt = best_mask_r;
    best_gw_nxt   = best_gw_r;
    best_port_nxt = best_port_r;
    if (take) begin
      best_hit_nxt  = 1'b1;
      best_mask_nxt = rd_entry_r.mask;
      best_gw_nxt   = rd_entry_r.gateway;
      best_port_nxt = rd_entry_r.port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      valid_r     <= '0;
      cmp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cmp_en_r <= (state_r == BK_SCAN);
      if (tbl_we) begin
        valid_r[wr_idx] <= 1'b1;
      end else if (vld_clr) begin
        valid_r[wr_idx] <= 1'b0;
      end
      if (load_zero || load_best) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // route table, one read per cycle during the scan
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      table_mem[wr_idx] <= wr_entry;
    end
    rd_entry_r <= table_mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    rd_vld_r <= valid_r[scan_idx_r];
    if (start_scan) begin
      scan_idx_r  <= '0;
      addr_r      <= cmd.key;
      best_hit_r  <= 1'b0;
      best_mask_r <= '0;
      best_gw_r   <= '0;
      best_port_r <= '0;
    end else begin
      if (state_r == BK_SCAN) begin
        scan_idx_r <= IDX_W'(scan_idx_r + 1'b1);
      end
      best_hit_r  <= best_hit_nxt;
      best_mask_r <= best_mask_nxt;
      best_gw_r   <= best_gw_nxt;
      best_port_r <= best_port_nxt;
    end
    if (load_zero) begin
      out_found_r <= 1'b0;
      out_hop_r   <= '0;
      out_port_r  <= '0;
    end else if (load_best) begin
      out_found_r <= best_hit_nxt;
      out_hop_r   <= best_hit_nxt ? best_gw_nxt : '0;
      out_port_r  <= best_hit_nxt ? best_port_nxt : '0;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.next_hop = out_hop_r;
  assign out_ch.out_port = out_port_r;

endmodule

// File: rtl/core/longest_prefix_route_lookup.sv
// longest-prefix route lookup over a table of ROUTES entries
// in_ch carries one command per transfer: lookup, write entry or invalidate
// entry; out_ch returns exactly one result per command, in command order
// (found, next_hop, out_port; all zero for writes, invalidates and misses)
// the front classifies commands and pushes them into a two-entry queue;
// the back executes them against a table memory with one read port
// a write or invalidate is executed when the back pops it from the queue: the
// back loads an all-zero result into its output register
// a lookup scans the table one entry per cycle through the memory read port,
// so it occupies the back through its scan and the final compare, and its
// best match is then loaded into the output register
// reset clears all entry valid bits, the queue and the output valid flag;
// entry contents are kept in memory and hold no reset value
// when the receiver stalls, the result waits in the output register and the
// back holds its next command; the queue keeps taking input until it is full
module longest_prefix_route_lookup #(
  parameter int ROUTES = lpr_pkg::LPR_ROUTES,
  parameter int PORTS  = lpr_pkg::LPR_PORTS
) (
  input  logic      clk,
  input  logic      rst_n,
  lpr_in_if.sink    in_ch,
  lpr_out_if.source out_ch
);
  import lpr_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  lpr_front #(
    .ROUTES (ROUTES),
    .PORTS  (PORTS)
  ) u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  lpr_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  lpr_back #(
    .ROUTES (ROUTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .out_ch    (out_ch)
  );

endmodule

// File: test/route_result_checker.sv
`timescale 1ns / 1ps
module route_result_checker
  import lpr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lpr_in_if    in_ch,
  lpr_out_if   out_ch,
  output int   error_count,
  output int   pending_count
);

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] next_hop;
    logic [PORT_W-1:0] out_port;
  } route_result_t;

  route_entry_t  route_tbl  [LPR_ROUTES];
  logic          route_live [LPR_ROUTES];
  route_result_t expected_routes [$];
  int            mismatches = 0;

  // longest mask wins, lowest slot on equal masks
  function automatic route_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
    route_result_t     res;
    logic [ADDR_W-1:0] best_mask;
    res = '0;
    best_mask = '0;
    for (int i = 0; i < LPR_ROUTES; i++) begin
      if (route_live[i] && ((addr & route_tbl[i].mask) == route_tbl[i].prefix) &&
          (!res.found || route_tbl[i].mask > best_mask)) begin
        res.found    = 1'b1;
        res.next_hop = route_tbl[i].gateway;
        res.out_port = route_tbl[i].port;
        best_mask    = route_tbl[i].mask;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    route_result_t     got;
    route_result_t     want;
    logic [PORT_W-1:0] port_sat;
    if (!rst_n) begin
      for (int i = 0; i < LPR_ROUTES; i++) begin
        route_live[i] = 1'b0;
      end
      expected_routes.delete();
    end else begin
      // results first: a result never belongs to a command taken at the same edge
      if (out_ch.valid && out_ch.ready) begin
        got.found    = out_ch.found;
        got.next_hop = out_ch.next_hop;
        got.out_port = out_ch.out_port;
        if (expected_routes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%t: unexpected result found=%0d next_hop=%h out_port=%0d",
                     $realtime, got.found, got.next_hop, got.out_port);
          end
        end else begin
          want = expected_routes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display({"%t: result mismatch exp found=%0d next_hop=%h out_port=%0d,",
                        " got found=%0d next_hop=%h out_port=%0d"},
                       $realtime, want.found, want.next_hop, want.out_port,
                       got.found, got.next_hop, got.out_port);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = '0;
        case (in_ch.action)
          ACT_LOOKUP: begin
            want = predict_lookup(in_ch.lookup_address);
          end
          ACT_WRITE: begin
            if (in_ch.entry_slot < LPR_ROUTES) begin
              port_sat = (in_ch.port_value >= LPR_PORTS) ? PORT_W'(LPR_PORTS - 1)
                                                          : in_ch.port_value;
              route_tbl[in_ch.entry_slot].prefix  = in_ch.prefix_value;
              route_tbl[in_ch.entry_slot].mask    = in_ch.prefix_mask;
              route_tbl[in_ch.entry_slot].gateway = in_ch.gateway_value;
              route_tbl[in_ch.entry_slot].port    = port_sat;
              route_live[in_ch.entry_slot]        = 1'b1;
            end
          end
          ACT_INVALIDATE: begin
            if (in_ch.entry_slot < LPR_ROUTES) begin
              route_live[in_ch.entry_slot] = 1'b0;
            end
          end
          default: begin
          end
        endcase
        expected_routes.push_back(want);
      end
    end
    error_count   = mismatches;
    pending_count = expected_routes.size();
  end

endmodule

// File: test/tb_longest_prefix_route_lookup.sv
`timescale 1ns / 1ps
module tb_longest_prefix_route_lookup;
  import lpr_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int LOOKUP_LATENCY = LPR_ROUTES + 3;
  localparam int RANDOM_ITEMS   = 1425;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   errors;
  int   pending;

  // what the sender has written, used to aim lookups at live prefixes
  logic [ADDR_W-1:0] sent_prefix  [LPR_ROUTES];
  logic [ADDR_W-1:0] sent_mask    [LPR_ROUTES];
  logic              sent_written [LPR_ROUTES];

  lpr_in_if  in_ch ();
  lpr_out_if out_ch ();

  longest_prefix_route_lookup dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  route_result_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .error_count   (errors),
    .pending_count (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] mask_of_len(input int len);
    return (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
  endfunction

  task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] slot,
                          input logic [ADDR_W-1:0] pfx, input logic [ADDR_W-1:0] msk,
                          input logic [ADDR_W-1:0] gw, input logic [PORT_W-1:0] port,
                          input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    in_ch.valid          = 1'b1;
    in_ch.action         = act;
    in_ch.entry_slot     = slot;
    in_ch.prefix_value   = pfx;
    in_ch.prefix_mask    = msk;
    in_ch.gateway_value  = gw;
    in_ch.port_value     = port;
    in_ch.lookup_address = addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (act == ACT_WRITE) begin
      sent_prefix[slot]  = pfx;
      sent_mask[slot]    = msk;
      sent_written[slot] = 1'b1;
    end
  endtask

  task automatic idle_input(input int cycles);
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_random_cmd();
    int                pick;
    int                len;
    logic [SLOT_W-1:0] s;
    logic [ADDR_W-1:0] msk;
    logic [ADDR_W-1:0] pfx;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    s    = SLOT_W'($urandom_range(0, LPR_ROUTES - 1));
    if (pick < 28) begin
      // byte-aligned lengths make equal-mask ties common
      if ($urandom_range(0, 2) == 0) len = 8 * $urandom_range(0, 4);
      else len = $urandom_range(0, 32);
      msk = mask_of_len(len);
      if ($urandom_range(0, 9) == 0) msk = $urandom;
      pfx = $urandom;
      if ($urandom_range(0, 7) != 0) pfx = pfx & msk;
      send_cmd(ACT_WRITE, s, pfx, msk, $urandom, PORT_W'($urandom_range(0, 3)), $urandom);
    end else if (pick < 38) begin
      send_cmd(ACT_INVALIDATE, s, $urandom, $urandom, $urandom,
               PORT_W'($urandom_range(0, 3)), $urandom);
    end else if (pick < 42) begin
      send_cmd(ACT_UNUSED, s, $urandom, $urandom, $urandom,
               PORT_W'($urandom_range(0, 3)), $urandom);
    end else begin
      addr = $urandom;
      if (sent_written[s] && $urandom_range(0, 4) != 0) begin
        addr = (sent_prefix[s] & sent_mask[s]) | (addr & ~sent_mask[s]);
      end
      send_cmd(ACT_LOOKUP, SLOT_W'($urandom_range(0, LPR_ROUTES - 1)), $urandom, $urandom,
               $urandom, PORT_W'($urandom_range(0, 3)), addr);
    end
  endtask

  // result side: changing stall patterns plus two long hold-offs
  initial begin
    int rx_cycles;
    int hold_left;
    int mode;
    int mode_left;
    out_ch.ready = 1'b0;
    rx_cycles = 0;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (rx_cycles == 900 || rx_cycles == 14000) hold_left = 300;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        case (mode)
          0:       out_ch.ready = 1'b1;
          1:       out_ch.ready = 1'($urandom_range(0, 1));
          2:       out_ch.ready = ($urandom_range(0, 3) == 0);
          default: out_ch.ready = ~out_ch.ready;
        endcase
      end
    end
  end

  initial begin
    int sent;
    int burst;
    in_ch.valid          = 1'b0;
    in_ch.action         = ACT_LOOKUP;
    in_ch.entry_slot     = '0;
    in_ch.prefix_value   = '0;
    in_ch.prefix_mask    = '0;
    in_ch.gateway_value  = '0;
    in_ch.port_value     = '0;
    in_ch.lookup_address = '0;
    for (int i = 0; i < LPR_ROUTES; i++) begin
      sent_written[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table, unused action code
    send_cmd(ACT_LOOKUP, 4'd0, '0, '0, '0, 2'd0, 32'h0000_0000);
    send_cmd(ACT_LOOKUP, 4'd0, '0, '0, '0, 2'd0, 32'hFFFF_FFFF);
    send_cmd(ACT_UNUSED, 4'd15, '1, '1, '1, 2'd3, 32'hFFFF_FFFF);
    // host route and default route at the slot extremes
    send_cmd(ACT_WRITE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 2'd0, '0);
    send_cmd(ACT_WRITE, 4'd0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 2'd3, '0);
    send_cmd(ACT_LOOKUP, 4'd0, '0, '0, '0, 2'd0, 32'hFFFF_FFFF);
    send_cmd(ACT_LOOKUP, 4'd0, '0, '0, '0, 2'd0, 32'h0000_0000);
    // equal masks: the lower slot wins
    send_cmd(ACT_WRITE, 4'd7, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0A00_0007, 2'd2, '0);
    send_cmd(ACT_WRITE, 4'd3, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0A00_0003, 2'd1, '0);
    send_cmd(ACT_LOOKUP, 4'd0, '0, '0, '0, 2'd0, 32'hC0A8_1234);
    send_cmd(ACT_WRITE, 4'd9, 32'hC0A8_1200, 32'hFFFF_FF00, 32'h0A00_0009, 2'd1, '0);
    send_cmd(ACT_LOOKUP, 4'd0, '0, '0, '0, 2'd0, 32'hC0A8_12FF);
    // prefix with bits outside its mask never matches
    send_cmd(ACT_WRITE, 4'd12, 32'h0A00_00FF, 32'hFFFF_FF00, 32'h1234_5678, 2'd3, '0);
    send_cmd(ACT_LOOKUP, 4'd0, '0, '0, '0, 2'd0, 32'h0A00_00FF);
    send_cmd(ACT_INVALIDATE, 4'd3, '0, '0, '0, 2'd0, '0);
    send_cmd(ACT_LOOKUP, 4'd0, '0, '0, '0, 2'd0, 32'hC0A8_5678);
    send_cmd(ACT_INVALIDATE, 4'd11, '0, '0, '0, 2'd0, '0);
    send_cmd(ACT_INVALIDATE, 4'd15, '0, '0, '0, 2'd0, '0);
    send_cmd(ACT_LOOKUP, 4'd0, '0, '0, '0, 2'd0, 32'hFFFF_FFFF);
    // top mask bit alone still beats the default route
    send_cmd(ACT_WRITE, 4'd1, 32'h8000_0000, 32'h8000_0000, 32'h5555_AAAA, 2'd2, '0);
    send_cmd(ACT_LOOKUP, 4'd0, '0, '0, '0, 2'd0, 32'hF000_0000);
    send_cmd(ACT_INVALIDATE, 4'd0, '0, '0, '0, 2'd0, '0);
    send_cmd(ACT_LOOKUP, 4'd0, '0, '0, '0, 2'd0, 32'h0000_0001);
    send_cmd(ACT_WRITE, 4'd3, 32'h0000_0000, 32'hFFFF_FFFE, 32'hAAAA_5555, 2'd1, '0);
    send_cmd(ACT_LOOKUP, 4'd0, '0, '0, '0, 2'd0, 32'h0000_0001);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        send_random_cmd();
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 12));
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LOOKUP_LATENCY + 8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lpr_pkg.sv
rtl/core/lpr_ifs.sv
rtl/core/lpr_front.sv
rtl/core/lpr_cmd_fifo.sv
rtl/core/lpr_back.sv
rtl/core/longest_prefix_route_lookup.sv
test/route_result_checker.sv
test/tb_longest_prefix_route_lookup.sv
